### rtl/tpcr_pkg.sv
// Package with shared types, codes and helpers for the texture pixel channel remap block.
`timescale 1ns / 1ps
`default_nettype none
package tpcr_pkg;

  // Signed Q3.12 sample, 4096 is one.
  typedef logic signed [15:0] q12_t;

  localparam q12_t Q_ONE  = 16'sd4096;
  localparam q12_t Q_HALF = 16'sd2048;

  // Positions of the flags inside the mode register.
  localparam int unsigned MODE_GRAY   = 0;
  localparam int unsigned MODE_FLIP   = 1;
  localparam int unsigned MODE_NORMAL = 2;
  localparam int unsigned MODE_OCCL   = 3;
  localparam int unsigned MODE_SRC_LO = 4;

  // Source select codes.
  typedef enum logic [2:0] {
    SRC_RGB = 3'd0,
    SRC_R   = 3'd1,
    SRC_G   = 3'd2,
    SRC_B   = 3'd3,
    SRC_A   = 3'd4
  } src_e;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_WEIGHT = 3'd1,
    REG_FILL   = 3'd2,
    REG_GAIN   = 3'd3,
    REG_OFFSET = 3'd4
  } reg_e;

  // Which result the output stage picks for red, green and blue.
  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_BLEND = 2'd1,
    KIND_GAIN  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  gray;
  } ctrl_t;

  typedef struct packed {
    logic [6:0]  mode;
    logic [12:0] weight;
    logic [63:0] fill;
    logic [47:0] gain;
    logic [47:0] offset;
  } cfg_t;

  // Clamp a wide signed value into the 16-bit sample range.
  function automatic q12_t sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7fff;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage
`default_nettype wire

### rtl/tpcr_cfg.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module tpcr_cfg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [5:0]     paddr,
  input  wire logic [63:0]    pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output tpcr_pkg::cfg_t      cfg_o
);
  import tpcr_pkg::*;

  cfg_t  cfg_q;
  cfg_t  cfg_d;
  reg_e  idx;
  logic  wr_en;

  assign idx    = reg_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MODE:   cfg_d.mode   = pwdata[6:0];
        REG_WEIGHT: cfg_d.weight = pwdata[12:0];
        REG_FILL:   cfg_d.fill   = pwdata;
        REG_GAIN:   cfg_d.gain   = pwdata[47:0];
        REG_OFFSET: cfg_d.offset = pwdata[47:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:   prdata = {57'd0, cfg_q.mode};
      REG_WEIGHT: prdata = {51'd0, cfg_q.weight};
      REG_FILL:   prdata = cfg_q.fill;
      REG_GAIN:   prdata = {16'd0, cfg_q.gain};
      REG_OFFSET: prdata = {16'd0, cfg_q.offset};
      default:    prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= 7'd0;
      cfg_q.weight <= 13'd4096;
      cfg_q.fill   <= 64'd0;
      cfg_q.gain   <= 48'd0;
      cfg_q.offset <= 48'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

### rtl/tpcr_front.sv
// First stage: mode decode, flip and selection of the blend and gain operands.
`timescale 1ns / 1ps
`default_nettype none
module tpcr_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tpcr_pkg::cfg_t cfg_i,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire tpcr_pkg::q12_t pix_i [4],
  output logic                valid_o,
  input  wire logic           ready_i,
  output tpcr_pkg::ctrl_t     ctrl_o,
  output tpcr_pkg::q12_t      pix_o [4],
  output tpcr_pkg::q12_t      x_o [3],
  output tpcr_pkg::q12_t      t_o [3],
  output tpcr_pkg::q12_t      gain_o [3],
  output tpcr_pkg::q12_t      off_o [3]
);
  import tpcr_pkg::*;

  logic       gray, flip, normal, occl, do_flip, src_ok;
  logic [2:0] src;
  logic [1:0] ch, gidx;
  q12_t       cf [4];
  q12_t       x_d [3], t_d [3], gain_d [3], off_d [3];
  ctrl_t      ctrl_d;

  logic       valid_q;
  ctrl_t      ctrl_q;
  q12_t       pix_q [4];
  q12_t       x_q [3], t_q [3], gain_q [3], off_q [3];
  logic       en;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    gray    = cfg_i.mode[MODE_GRAY];
    flip    = cfg_i.mode[MODE_FLIP];
    normal  = cfg_i.mode[MODE_NORMAL];
    occl    = cfg_i.mode[MODE_OCCL];
    src     = cfg_i.mode[MODE_SRC_LO +: 3];
    do_flip = flip && !(!gray && normal);
    src_ok  = (src >= SRC_R) && (src <= SRC_A);
    ch      = src_ok ? 2'(src - 3'd1) : 2'd0;
    gidx    = (ch == 2'd3) ? 2'd0 : ch;

    for (int i = 0; i < 4; i++) begin
      cf[i] = do_flip ? sat16(32'sd4096 - {{16{pix_i[i][15]}}, pix_i[i]}) : pix_i[i];
    end
    for (int i = 0; i < 3; i++) begin
      x_d[i]    = cf[i];
      t_d[i]    = cfg_i.fill[16*i +: 16];
      gain_d[i] = cfg_i.gain[16*i +: 16];
      off_d[i]  = cfg_i.offset[16*i +: 16];
    end

    ctrl_d.kind = KIND_PASS;
    ctrl_d.gray = 1'b0;
    if (!gray && normal) begin
      ctrl_d.kind = KIND_BLEND;
      t_d[0] = Q_HALF;
      t_d[1] = Q_HALF;
      t_d[2] = Q_ONE;
    end else if (!gray && occl) begin
      ctrl_d.kind = KIND_BLEND;
      ctrl_d.gray = 1'b1;
      x_d[0] = cf[ch];
      t_d[0] = Q_ONE;
    end else if (src_ok) begin
      ctrl_d.kind = KIND_GAIN;
      ctrl_d.gray = 1'b1;
      x_d[0]    = cf[ch];
      t_d[0]    = cfg_i.fill[{ch, 4'b0000} +: 16];
      gain_d[0] = cfg_i.gain[{gidx, 4'b0000} +: 16];
      off_d[0]  = cfg_i.offset[{gidx, 4'b0000} +: 16];
    end else if (!gray && (src == SRC_RGB)) begin
      ctrl_d.kind = KIND_GAIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      ctrl_q <= ctrl_d;
      pix_q  <= cf;
      x_q    <= x_d;
      t_q    <= t_d;
      gain_q <= gain_d;
      off_q  <= off_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign pix_o   = pix_q;
  assign x_o     = x_q;
  assign t_o     = t_q;
  assign gain_o  = gain_q;
  assign off_o   = off_q;

endmodule
`default_nettype wire

### rtl/tpcr_blend.sv
// Blend stages: weighted products, then rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module tpcr_blend (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [12:0]     weight_i,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire tpcr_pkg::ctrl_t ctrl_i,
  input  wire tpcr_pkg::q12_t  pix_i [4],
  input  wire tpcr_pkg::q12_t  x_i [3],
  input  wire tpcr_pkg::q12_t  t_i [3],
  input  wire tpcr_pkg::q12_t  gain_i [3],
  input  wire tpcr_pkg::q12_t  off_i [3],
  output logic                 valid_o,
  input  wire logic            ready_i,
  output tpcr_pkg::ctrl_t      ctrl_o,
  output tpcr_pkg::q12_t       pix_o [4],
  output tpcr_pkg::q12_t       blend_o [3],
  output tpcr_pkg::q12_t       gain_o [3],
  output tpcr_pkg::q12_t       off_o [3]
);
  import tpcr_pkg::*;

  logic signed [13:0] w_s, omw_s;
  logic signed [29:0] pa_d [3], pb_d [3];
  logic signed [31:0] sum [3];
  q12_t               blend_d [3];

  // Product stage.
  logic               v2_q;
  ctrl_t              ctrl2_q;
  q12_t               pix2_q [4], gain2_q [3], off2_q [3];
  logic signed [29:0] pa_q [3], pb_q [3];
  // Round and clamp stage.
  logic               v3_q;
  ctrl_t              ctrl3_q;
  q12_t               pix3_q [4], gain3_q [3], off3_q [3], blend3_q [3];
  logic               en2, en3;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign ready_o = en2;

  always_comb begin
    w_s   = $signed({1'b0, weight_i});
    omw_s = 14'sd4096 - w_s;
    for (int i = 0; i < 3; i++) begin
      pa_d[i] = x_i[i] * w_s;
      pb_d[i] = t_i[i] * omw_s;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = {{2{pa_q[i][29]}}, pa_q[i]} + {{2{pb_q[i][29]}}, pb_q[i]} + 32'sd2048;
      blend_d[i] = sat16(sum[i] >>> 12);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en2) begin
        v2_q <= valid_i;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && valid_i) begin
      ctrl2_q <= ctrl_i;
      pix2_q  <= pix_i;
      gain2_q <= gain_i;
      off2_q  <= off_i;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
    end
    if (en3 && v2_q) begin
      ctrl3_q  <= ctrl2_q;
      pix3_q   <= pix2_q;
      gain3_q  <= gain2_q;
      off3_q   <= off2_q;
      blend3_q <= blend_d;
    end
  end

  assign valid_o = v3_q;
  assign ctrl_o  = ctrl3_q;
  assign pix_o   = pix3_q;
  assign blend_o = blend3_q;
  assign gain_o  = gain3_q;
  assign off_o   = off3_q;

endmodule
`default_nettype wire

### rtl/tpcr_gain.sv
// Gain stages: gain product, then rounding, offset, clamp and output selection.
`timescale 1ns / 1ps
`default_nettype none
module tpcr_gain (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire tpcr_pkg::ctrl_t ctrl_i,
  input  wire tpcr_pkg::q12_t  pix_i [4],
  input  wire tpcr_pkg::q12_t  blend_i [3],
  input  wire tpcr_pkg::q12_t  gain_i [3],
  input  wire tpcr_pkg::q12_t  off_i [3],
  output logic                 valid_o,
  input  wire logic            ready_i,
  output tpcr_pkg::q12_t       pix_o [4]
);
  import tpcr_pkg::*;

  logic signed [31:0] prod_d [3];
  logic signed [31:0] acc [3];
  q12_t               res [3];
  q12_t               rgb [3];
  q12_t               out_d [4];

  logic               v4_q;
  ctrl_t              ctrl4_q;
  q12_t               pix4_q [4], blend4_q [3], off4_q [3];
  logic signed [31:0] prod_q [3];
  logic               v5_q;
  q12_t               out_q [4];
  logic               en4, en5;

  assign en5     = !v5_q || ready_i;
  assign en4     = !v4_q || en5;
  assign ready_o = en4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = blend_i[i] * gain_i[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ((prod_q[i] + 32'sd2048) >>> 12) +
               $signed({{16{off4_q[i][15]}}, off4_q[i]});
      res[i] = sat16(acc[i]);
    end
    case (ctrl4_q.kind)
      KIND_BLEND: rgb = blend4_q;
      KIND_GAIN:  rgb = res;
      default: begin
        for (int i = 0; i < 3; i++) begin
          rgb[i] = pix4_q[i];
        end
      end
    endcase
    if (ctrl4_q.gray) begin
      out_d[0] = rgb[0];
      out_d[1] = rgb[0];
      out_d[2] = rgb[0];
      out_d[3] = Q_ONE;
    end else begin
      out_d[0] = rgb[0];
      out_d[1] = rgb[1];
      out_d[2] = rgb[2];
      out_d[3] = pix4_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en4) begin
        v4_q <= valid_i;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && valid_i) begin
      ctrl4_q  <= ctrl_i;
      pix4_q   <= pix_i;
      blend4_q <= blend_i;
      off4_q   <= off_i;
      prod_q   <= prod_d;
    end
    if (en5 && v4_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = v5_q;
  assign pix_o   = out_q;

endmodule
`default_nettype wire

### rtl/texture_pixel_channel_remap_top.sv
// Top level of the texture pixel channel remap block.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Handshake                   Payload
//  -------   -------------------------   --------------------------------------------
//  input     in_valid_i / in_ready_o     in_red_i, in_green_i, in_blue_i, in_alpha_i
//  output    out_valid_o / out_ready_i   out_red_o, out_green_o, out_blue_o, out_alpha_o
//  config    psel, penable, pwrite       paddr, pwdata, prdata (pready tied high)
//
//  The datapath is five register stages deep: decode and flip, blend products,
//  blend rounding, gain product, and gain rounding with output selection.
//  One word enters per cycle while no stall holds the pipeline; the two
//  multiplier stages accept a new word every cycle unless stalled.
//  Each stage has its own valid bit and advances when it is empty or the next stage
//  moves, so bubbles close up and a stall holds every word in place.
//  Reset clears the valid bits and loads the register reset values.
//
module texture_pixel_channel_remap_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] in_red_i,
  input  wire logic [15:0] in_green_i,
  input  wire logic [15:0] in_blue_i,
  input  wire logic [15:0] in_alpha_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      out_red_o,
  output logic [15:0]      out_green_o,
  output logic [15:0]      out_blue_o,
  output logic [15:0]      out_alpha_o
);
  import tpcr_pkg::*;

  cfg_t  cfg;
  q12_t  pix_in [4];

  // Handshake between the front stage and the blend stages.
  logic  f_valid, f_ready;
  ctrl_t f_ctrl;
  q12_t  f_pix [4], f_x [3], f_t [3], f_gain [3], f_off [3];

  // Handshake between the blend stages and the gain stages.
  logic  b_valid, b_ready;
  ctrl_t b_ctrl;
  q12_t  b_pix [4], b_blend [3], b_gain [3], b_off [3];

  q12_t  pix_out [4];

  assign pix_in[0] = in_red_i;
  assign pix_in[1] = in_green_i;
  assign pix_in[2] = in_blue_i;
  assign pix_in[3] = in_alpha_i;

  tpcr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tpcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .pix_i   (pix_in),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .ctrl_o  (f_ctrl),
    .pix_o   (f_pix),
    .x_o     (f_x),
    .t_o     (f_t),
    .gain_o  (f_gain),
    .off_o   (f_off)
  );

  // The weight is read straight from its register; the user must change it only
  // while the pipeline is empty, as the block does not enforce this.
  tpcr_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .weight_i (cfg.weight),
    .valid_i  (f_valid),
    .ready_o  (f_ready),
    .ctrl_i   (f_ctrl),
    .pix_i    (f_pix),
    .x_i      (f_x),
    .t_i      (f_t),
    .gain_i   (f_gain),
    .off_i    (f_off),
    .valid_o  (b_valid),
    .ready_i  (b_ready),
    .ctrl_o   (b_ctrl),
    .pix_o    (b_pix),
    .blend_o  (b_blend),
    .gain_o   (b_gain),
    .off_o    (b_off)
  );

  tpcr_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_valid),
    .ready_o (b_ready),
    .ctrl_i  (b_ctrl),
    .pix_i   (b_pix),
    .blend_i (b_blend),
    .gain_i  (b_gain),
    .off_i   (b_off),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .pix_o   (pix_out)
  );

  assign out_red_o   = pix_out[0];
  assign out_green_o = pix_out[1];
  assign out_blue_o  = pix_out[2];
  assign out_alpha_o = pix_out[3];

endmodule
`default_nettype wire

### rtl/tpcr_checker.sv
// Port-level checker for the texture pixel channel remap block and its bind.
`timescale 1ns / 1ps
`default_nettype none
module tpcr_sva (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_red_o,
  input wire logic [15:0] out_green_o,
  input wire logic [15:0] out_blue_o,
  input wire logic [15:0] out_alpha_o
);

  logic       in_acc, out_acc;
  logic [2:0] cnt_q, cnt_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A waiting result word holds still until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_red_o) &&
    $stable(out_green_o) && $stable(out_blue_o) && $stable(out_alpha_o))
    else $error("output word changed while stalled");

  // With the sink ready every stage moves, so the input side is never blocked.
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output is ready");

  // Every result word belongs to an earlier accepted input word.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 3'd0)
    else $error("result word without an input word");

  // No more words in flight than pipeline stages.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd5)
    else $error("too many words in flight");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("configuration port not ready");

endmodule

bind texture_pixel_channel_remap_top tpcr_sva u_tpcr_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pready      (pready),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_red_o   (out_red_o),
  .out_green_o (out_green_o),
  .out_blue_o  (out_blue_o),
  .out_alpha_o (out_alpha_o)
);
`default_nettype wire

### bench/tpcr_checker.sv
// Checker that predicts each remapped pixel and compares it with the block's output words.
`timescale 1ns / 1ps
module tpcr_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_o,
  input  wire logic [15:0] in_red_i,
  input  wire logic [15:0] in_green_i,
  input  wire logic [15:0] in_blue_i,
  input  wire logic [15:0] in_alpha_i,
  input  wire logic        out_valid_o,
  input  wire logic        out_ready_i,
  input  wire logic [15:0] out_red_o,
  input  wire logic [15:0] out_green_o,
  input  wire logic [15:0] out_blue_o,
  input  wire logic [15:0] out_alpha_o,
  output int               mismatch_count_o,
  output int               pending_count_o
);
  import tpcr_pkg::*;

  // Channel 0 is red, then green, blue and alpha.
  typedef logic [3:0][15:0] pixel_t;

  logic [6:0]  mode_q;
  logic [12:0] weight_q;
  logic [63:0] fill_q;
  logic [47:0] gain_q;
  logic [47:0] offset_q;

  pixel_t expected_pixels [$];
  int     mismatch_total = 0;
  string  channel_names [4] = '{"red", "green", "blue", "alpha"};

  function automatic longint saturate_q12(longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Round a Q7.24 product to Q3.12, half rounding up, floor toward minus infinity.
  function automatic longint round_q12(longint x);
    return (x + Q_HALF) >>> 12;
  endfunction

  function automatic longint lane_of(logic [63:0] word, int idx);
    q12_t s;
    s = word[idx*16 +: 16];
    return s;
  endfunction

  function automatic longint blend_toward(longint v, longint target);
    longint w;
    w = longint'(weight_q);
    return saturate_q12(round_q12(v * w + target * (Q_ONE - w)));
  endfunction

  function automatic longint apply_gain(longint v, int idx);
    return saturate_q12(round_q12(v * lane_of(64'(gain_q), idx)) +
                        lane_of(64'(offset_q), idx));
  endfunction

  function automatic pixel_t remap_pixel(pixel_t px);
    longint     c [4];
    longint     level;
    logic [2:0] src;
    int         ch;
    pixel_t     res;
    src = mode_q[MODE_SRC_LO +: 3];
    for (int i = 0; i < 4; i++) begin
      c[i] = q12_t'(px[i]);
    end
    if (!mode_q[MODE_GRAY] && mode_q[MODE_NORMAL]) begin
      c[0] = blend_toward(c[0], Q_HALF);
      c[1] = blend_toward(c[1], Q_HALF);
      c[2] = blend_toward(c[2], Q_ONE);
    end else begin
      if (mode_q[MODE_FLIP]) begin
        for (int i = 0; i < 4; i++) begin
          c[i] = saturate_q12(Q_ONE - c[i]);
        end
      end
      if (!mode_q[MODE_GRAY] && mode_q[MODE_OCCL]) begin
        // Occlusion falls back to red when the source code is not a single channel.
        ch = (src >= SRC_R && src <= SRC_A) ? src - SRC_R : 0;
        level = blend_toward(c[ch], Q_ONE);
        c[0] = level;
        c[1] = level;
        c[2] = level;
        c[3] = Q_ONE;
      end else if (src >= SRC_R && src <= SRC_A) begin
        // The alpha source borrows the red gain and offset.
        ch = src - SRC_R;
        level = apply_gain(blend_toward(c[ch], lane_of(fill_q, ch)), (src == SRC_A) ? 0 : ch);
        c[0] = level;
        c[1] = level;
        c[2] = level;
        c[3] = Q_ONE;
      end else if (!mode_q[MODE_GRAY] && src == SRC_RGB) begin
        for (int i = 0; i < 3; i++) begin
          c[i] = apply_gain(blend_toward(c[i], lane_of(fill_q, i)), i);
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      res[i] = c[i][15:0];
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] seen);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, seen);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_t seen;
    pixel_t want;
    if (!rst_ni) begin
      mode_q          <= '0;
      weight_q        <= 13'd4096;
      fill_q          <= '0;
      gain_q          <= '0;
      offset_q        <= '0;
      pending_count_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen = {out_alpha_o, out_blue_o, out_green_o, out_red_o};
        if (expected_pixels.size() == 0) begin
          note_mismatch("unexpected word, alpha blue green red", '0, seen[3]);
        end else begin
          want = expected_pixels.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (seen[i] !== want[i]) begin
              note_mismatch(channel_names[i], want[i], seen[i]);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_pixels.insert(expected_pixels.size(),
                               remap_pixel({in_alpha_i, in_blue_i, in_green_i, in_red_i}));
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_e'(paddr[5:3]))
          REG_MODE:   mode_q   <= pwdata[6:0];
          REG_WEIGHT: weight_q <= pwdata[12:0];
          REG_FILL:   fill_q   <= pwdata;
          REG_GAIN:   gain_q   <= pwdata[47:0];
          REG_OFFSET: offset_q <= pwdata[47:0];
          default: ;
        endcase
      end
      pending_count_o  <= expected_pixels.size();
      mismatch_count_o <= mismatch_total;
    end
  end

endmodule

### bench/testbench.sv
// Top of the texture pixel channel remap bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import tpcr_pkg::*;

  // Five register stages between an accepted input word and its output word.
  localparam int unsigned PIPE_DEPTH      = 5;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned LONG_STALL      = 64;
  localparam int unsigned RANDOM_PHASES   = 16;
  localparam int unsigned WORDS_PER_PHASE = 100;
  localparam int unsigned DIRECTED_GROUPS = 9;

  // Source codes that select no channel.
  localparam logic [2:0] SRC_UNUSED_LO = 3'd5;
  localparam logic [2:0] SRC_UNUSED_HI = 3'd7;

  localparam logic [15:0] EXTREMES [6] = '{16'h8000, 16'h7fff, 16'h0000,
                                           16'h1000, 16'hffff, 16'h0800};

  // Processing path that a random phase aims at.
  typedef enum int {
    PATH_GRAY,
    PATH_NORMAL,
    PATH_OCCL,
    PATH_COLOR
  } path_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [5:0]  paddr       = '0;
  logic [63:0] pwdata      = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [15:0] in_red_i    = '0;
  logic [15:0] in_green_i  = '0;
  logic [15:0] in_blue_i   = '0;
  logic [15:0] in_alpha_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] out_red_o;
  logic [15:0] out_green_o;
  logic [15:0] out_blue_o;
  logic [15:0] out_alpha_o;

  int mismatch_count;
  int pending_count;

  // Idle rates in percent per cycle, changed by the stimulus between phases.
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 47;

  // The stimulus toggles hold_request; the receiver process owns the stall counter.
  logic        hold_request = 1'b0;
  logic        hold_seen    = 1'b0;
  int unsigned hold_left    = 0;

  longint unsigned cycle_count = 0;

  texture_pixel_channel_remap_top dut (.*);

  tpcr_checker checker_i (
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .*
  );

  always #5 clk_i = ~clk_i;

  // A hung handshake or a lost word ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Output side: random back-pressure, plus one long hold-off on request so that
  // the pipeline fills and the block has to drop in_ready_o.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_request != hold_seen) begin
      out_ready_i <= 1'b0;
      hold_seen   <= hold_request;
      hold_left   <= LONG_STALL;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [6:0] make_mode(logic gray, logic flip, logic normal, logic occl,
                                           logic [2:0] src);
    logic [6:0] m;
    m = '0;
    m[MODE_GRAY]          = gray;
    m[MODE_FLIP]          = flip;
    m[MODE_NORMAL]        = normal;
    m[MODE_OCCL]          = occl;
    m[MODE_SRC_LO +: 3]   = src;
    return m;
  endfunction

  // Half of the lanes are small Q3.12 values, the rest hit the rails or any bit pattern.
  function automatic logic [15:0] random_lane();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'(int'($urandom_range(16384)) - 8192);
    endcase
  endfunction

  // Samples are either any 16-bit pattern or a value near the normal 0..2 range.
  function automatic logic [15:0] random_sample();
    if ($urandom_range(1)) begin
      return 16'($urandom);
    end
    return 16'(int'($urandom_range(12288)) - 4096);
  endfunction

  // One APB write: setup cycle, then access cycle; the register loads at the
  // edge that ends the access cycle.
  task automatic write_reg(reg_e idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_registers(logic [6:0] mode, logic [12:0] weight, logic [63:0] fill,
                               logic [47:0] gain, logic [47:0] offset);
    write_reg(REG_MODE, 64'(mode));
    write_reg(REG_WEIGHT, 64'(weight));
    write_reg(REG_FILL, fill);
    write_reg(REG_GAIN, 64'(gain));
    write_reg(REG_OFFSET, 64'(offset));
  endtask

  // Offers one word and returns at the edge where it is accepted, with valid
  // still high so that a following word can go out back to back.
  task automatic send_pixel(logic [15:0] red, logic [15:0] green, logic [15:0] blue,
                            logic [15:0] alpha);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_red_i   <= red;
    in_green_i <= green;
    in_blue_i  <= blue;
    in_alpha_i <= alpha;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
  endtask

  // Stops offering, waits until every predicted word has come out, then lets
  // the pipeline settle. The first edge lets the checker count the last word.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) begin
      @(posedge clk_i);
    end
    repeat (2 * PIPE_DEPTH) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned n;
    path_e       path;
    logic [2:0]  src;
    logic [12:0] weight;
    logic        gray_path;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The first group runs on the reset values; each later group
    // loads a corner setting, and every group sends a few rail-to-rail pixels.
    for (int g = 0; g < DIRECTED_GROUPS; g++) begin
      if (g > 0) begin
        wait_for_results();
        case (g)
          // Normal map ignores the flip bit; zero weight gives the flat normal.
          1: set_registers(make_mode(1'b0, 1'b1, 1'b1, 1'b0, SRC_RGB), 13'd0,
                           {4{16'h7fff}}, {3{16'h7fff}}, {3{16'h8000}});
          // Flipped occlusion taken from alpha.
          2: set_registers(make_mode(1'b0, 1'b1, 1'b0, 1'b1, SRC_A), 13'd2048,
                           '0, '0, '0);
          // Occlusion with a source code that names no channel, weight above one.
          3: set_registers(make_mode(1'b0, 1'b0, 1'b0, 1'b1, SRC_UNUSED_HI), 13'd8191,
                           {4{16'h1234}}, {3{16'h1000}}, '0);
          // Grayscale with RGB source only flips; normal and occlusion bits are ignored.
          4: set_registers(make_mode(1'b1, 1'b1, 1'b1, 1'b1, SRC_RGB), 13'd0,
                           {4{16'h8000}}, {3{16'h7fff}}, {3{16'h7fff}});
          // Grayscale from green with the largest gain and offset.
          5: set_registers(make_mode(1'b1, 1'b0, 1'b0, 1'b0, SRC_G), 13'd4096,
                           '0, {3{16'h7fff}}, {3{16'h7fff}});
          // Colour path, flipped, every lane at the negative rail.
          6: set_registers(make_mode(1'b0, 1'b1, 1'b0, 1'b0, SRC_RGB), 13'd1000,
                           {4{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
          // Alpha source outside grayscale mode picks up the red gain and offset.
          7: set_registers(make_mode(1'b0, 1'b0, 1'b0, 1'b0, SRC_A), 13'd3000,
                           64'h1000_0800_f000_7fff, 48'h0000_4000_2000, 48'h0000_0000_1000);
          // Unknown source outside occlusion only flips.
          default: set_registers(make_mode(1'b0, 1'b1, 1'b0, 1'b0, SRC_UNUSED_LO), 13'd4096,
                                 {4{16'h4000}}, {3{16'h2000}}, {3{16'h0100}});
        endcase
      end
      for (int j = 0; j < 3; j++) begin
        n = 3 * g + j;
        send_pixel(EXTREMES[n % 6], EXTREMES[(n + 1) % 6], EXTREMES[(n + 2) % 6],
                   EXTREMES[(n + 3) % 6]);
      end
    end

    // Random part. Each phase loads a fresh setting aimed at one processing path.
    // The first third idles the sender lightly and the receiver heavily, the
    // second third the other way round, and the last third runs without gaps.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES / 3) begin
        send_idle_pct = 47;
        recv_idle_pct = 18;
      end
      if (p == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_for_results();

      path = path_e'($urandom_range(3));
      if ($urandom_range(7) == 0) begin
        src = 3'($urandom_range(SRC_UNUSED_HI, SRC_UNUSED_LO));
      end else begin
        src = 3'($urandom_range(int'(SRC_A)));
      end
      case ($urandom_range(5))
        0:       weight = 13'd0;
        1:       weight = 13'd4096;
        2:       weight = 13'd8191;
        3:       weight = 13'($urandom_range(8191, 4097));
        default: weight = 13'($urandom_range(4096));
      endcase
      // In grayscale the normal and occlusion bits are don't-cares, so set them at random.
      gray_path = (path == PATH_GRAY);
      set_registers(make_mode(gray_path, 1'($urandom_range(1)),
                              path == PATH_NORMAL || (gray_path && $urandom_range(1)),
                              path == PATH_OCCL || (gray_path && $urandom_range(1)), src),
                    weight,
                    {random_lane(), random_lane(), random_lane(), random_lane()},
                    {random_lane(), random_lane(), random_lane()},
                    {random_lane(), random_lane(), random_lane()});

      // In the first gap-free phase the receiver holds off for a long stretch
      // while the sender keeps offering, so the block must stall its input.
      if (p == 2 * RANDOM_PHASES / 3) begin
        hold_request <= ~hold_request;
      end

      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        send_pixel(random_sample(), random_sample(), random_sample(), random_sample());
      end
    end

    wait_for_results();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
